// ----- design/windowed_average_and_minimum_top_assert.svh -----
// Assertion macros for the windowed average and minimum block.
// Included by the top level; needs no other file.
`ifndef WINDOWED_AVERAGE_AND_MINIMUM_TOP_ASSERT_SVH
`define WINDOWED_AVERAGE_AND_MINIMUM_TOP_ASSERT_SVH

// same-cycle implication
`define WAM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define WAM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/wam_pkg.sv -----
// Shared constants and types of the windowed average and minimum block.
// No dependencies.
package wam_pkg;

  localparam int CFG_BITS      = 9;
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  localparam logic [CFG_BITS-1:0] WINDOW_SIZE_RESET = 9'd16;

  // register index, taken from paddr[2]
  localparam logic REG_WINDOW_SIZE = 1'b0;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ----- design/windowed_average_and_minimum_top.sv -----
// Windowed average and minimum: sample chain of cells, scan control,
// serial divider. Uses wam_pkg, wam_cell, wam_div and the assert header.
//
// Usage:
//   Samples enter on sample_valid_i/sample_ready_o with sample_i. Each
//   request yields one result on result_valid_o/result_ready_i: average,
//   window sum, held count and window minimum of the last window_size
//   samples.
//   window_size sits at APB address 0; any write to it empties the window.
//   Write it only while the block is idle.
// Operation:
//   The scan rotates the whole cell chain past the scan comparator, the
//   update state shifts the sample in and starts the divider, which forms
//   the quotient bit by bit, and the hold state loads the output register.
//   A new sample is taken only once the last result has been loaded.
// Reset:
//   Window empty, window_size = 16. Cell contents are not cleared.
// Stall:
//   A finished result holds in the output register; the next sample is
//   taken and worked on meanwhile and waits until the register is free.
module windowed_average_and_minimum_top #(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 16,
  localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW_MAX),
  localparam int CNT_BITS   = $clog2(WINDOW_MAX + 1)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [wam_pkg::APB_ADDR_BITS-1:0]     paddr,
  input  logic [wam_pkg::APB_DATA_BITS-1:0]     pwdata,
  output logic [wam_pkg::APB_DATA_BITS-1:0]     prdata,
  output logic                                  pready,
  input  logic                                  sample_valid_i,
  output logic                                  sample_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]         sample_i,
  output logic                                  result_valid_o,
  input  logic                                  result_ready_i,
  output logic signed [SAMPLE_BITS-1:0]         average_o,
  output logic signed [SUM_BITS-1:0]            window_sum_o,
  output logic        [CNT_BITS-1:0]            held_count_o,
  output logic signed [SAMPLE_BITS-1:0]         window_minimum_o
);

  `include "windowed_average_and_minimum_top_assert.svh"

  localparam int IDX_BITS = $clog2(WINDOW_MAX);
  localparam int WIDE     = (CNT_BITS > wam_pkg::CFG_BITS) ? CNT_BITS : wam_pkg::CFG_BITS;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_DIVIDE = 3'd3;
  localparam logic [2:0] ST_HOLD   = 3'd4;

  logic [2:0]                      st_q;
  logic [wam_pkg::CFG_BITS-1:0]    ws_q;
  logic [CNT_BITS-1:0]             fill_q;
  logic signed [SUM_BITS-1:0]      sum_q;
  logic [IDX_BITS-1:0]             idx_q;
  logic signed [SAMPLE_BITS-1:0]   min_q;
  logic signed [SAMPLE_BITS-1:0]   drop_q;
  logic signed [SAMPLE_BITS-1:0]   sample_q;

  logic                            ovalid_q;
  logic signed [SAMPLE_BITS-1:0]   oavg_q;
  logic signed [SUM_BITS-1:0]      osum_q;
  logic [CNT_BITS-1:0]             ocnt_q;
  logic signed [SAMPLE_BITS-1:0]   omin_q;

  logic                            cfg_wr;
  logic                            in_acc;
  logic [WIDE-1:0]                 ws_wide;
  logic [CNT_BITS-1:0]             cap;
  logic                            full;
  logic [CNT_BITS-1:0]             lim;
  logic [CNT_BITS-1:0]             idx_ext;
  logic signed [SUM_BITS-1:0]      sum_d;
  logic [CNT_BITS-1:0]             fill_d;

  logic                            chain_en;
  logic signed [SAMPLE_BITS-1:0]   head_d;
  logic signed [SAMPLE_BITS-1:0]   chain [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0]   tail;

  logic [SAMPLE_BITS-1:0]          quot;
  wam_pkg::div_status_t            div_st;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == wam_pkg::REG_WINDOW_SIZE);
  always_comb begin
    prdata = '0;
    if (paddr[2] == wam_pkg::REG_WINDOW_SIZE) begin
      prdata = {{(wam_pkg::APB_DATA_BITS - wam_pkg::CFG_BITS){1'b0}}, ws_q};
    end
  end

  // capacity: zero acts as one, above WINDOW_MAX saturates
  assign ws_wide = WIDE'(ws_q);
  always_comb begin
    cap = CNT_BITS'(ws_wide);
    if (ws_wide == '0) begin
      cap = CNT_BITS'(1);
    end else if (ws_wide > WIDE'(WINDOW_MAX)) begin
      cap = CNT_BITS'(WINDOW_MAX);
    end
  end

  assign full    = fill_q >= cap;
  assign lim     = full ? cap - 1'b1 : fill_q;
  assign idx_ext = CNT_BITS'(idx_q);
  assign sum_d   = sum_q + SUM_BITS'(sample_q) - (full ? SUM_BITS'(drop_q) : '0);
  assign fill_d  = full ? fill_q : fill_q + 1'b1;

  assign sample_ready_o = st_q == ST_IDLE;
  assign in_acc         = sample_valid_i && sample_ready_o;

  // cell chain: rotates during the scan, shifts the new sample in on update
  assign chain_en = (st_q == ST_SCAN) || (st_q == ST_UPDATE);
  assign tail     = chain[WINDOW_MAX-1];
  assign head_d   = (st_q == ST_UPDATE) ? sample_q : tail;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    if (i == 0) begin : g_head
      wam_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk_i (clk_i),
        .en_i  (chain_en),
        .d_i   (head_d),
        .q_o   (chain[i])
      );
    end else begin : g_body
      wam_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk_i (clk_i),
        .en_i  (chain_en),
        .d_i   (chain[i-1]),
        .q_o   (chain[i])
      );
    end
  end

  wam_div #(
    .SUM_BITS (SUM_BITS),
    .CNT_BITS (CNT_BITS),
    .Q_BITS   (SAMPLE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (st_q == ST_UPDATE),
    .dividend_i (sum_d),
    .divisor_i  (fill_d),
    .quotient_o (quot),
    .status_o   (div_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      ws_q     <= wam_pkg::WINDOW_SIZE_RESET;
      fill_q   <= '0;
      sum_q    <= '0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (ovalid_q && result_ready_i && (st_q != ST_HOLD)) begin
        ovalid_q <= 1'b0;
      end
      if (cfg_wr) begin
        ws_q   <= pwdata[wam_pkg::CFG_BITS-1:0];
        fill_q <= '0;
        sum_q  <= '0;
      end
      case (st_q)
        ST_IDLE: begin
          if (in_acc) begin
            idx_q <= IDX_BITS'(WINDOW_MAX - 1);
            st_q  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          idx_q <= idx_q - 1'b1;
          if (idx_q == '0) begin
            st_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          sum_q  <= sum_d;
          fill_q <= fill_d;
          st_q   <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (div_st.done) begin
            st_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (!ovalid_q || result_ready_i) begin
            ovalid_q <= 1'b1;
            st_q     <= ST_IDLE;
          end
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath: tail holds original cell idx_q during the scan
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= sample_i;
      min_q    <= sample_i;
    end
    if (st_q == ST_SCAN) begin
      if ((idx_ext < lim) && (tail < min_q)) begin
        min_q <= tail;
      end
      if (idx_ext == cap - 1'b1) begin
        drop_q <= tail;
      end
    end
    if ((st_q == ST_HOLD) && (!ovalid_q || result_ready_i)) begin
      oavg_q <= quot;
      osum_q <= sum_q;
      ocnt_q <= fill_q;
      omin_q <= min_q;
    end
  end

  assign result_valid_o   = ovalid_q;
  assign average_o        = oavg_q;
  assign window_sum_o     = osum_q;
  assign held_count_o     = ocnt_q;
  assign window_minimum_o = omin_q;

  `WAM_ASSERT_NXT(a_accept_scan, clk_i, rst_ni, in_acc, st_q == ST_SCAN)
  `WAM_ASSERT_IMP(a_fill_cap, clk_i, rst_ni, 1'b1, fill_q <= cap)
  `WAM_ASSERT_IMP(a_div_done, clk_i, rst_ni, div_st.done, st_q == ST_DIVIDE)
  `WAM_ASSERT_IMP(a_scan_div_idle, clk_i, rst_ni, st_q == ST_SCAN, !div_st.busy)

endmodule

// ----- design/wam_cell.sv -----
// One storage cell of the sample chain.
// Takes the neighbor's sample when enabled. No dependencies.
module wam_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [SAMPLE_BITS-1:0] d_i,
  output logic signed [SAMPLE_BITS-1:0] q_o
);

  logic signed [SAMPLE_BITS-1:0] sample_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sample_q <= d_i;
    end
  end

  assign q_o = sample_q;

endmodule

// ----- design/wam_div.sv -----
// Bit-serial signed by unsigned divider, quotient truncated toward zero.
// One quotient bit per cycle. Uses wam_pkg.
module wam_div #(
  parameter int SUM_BITS = 24,
  parameter int CNT_BITS = 9,
  parameter int Q_BITS   = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [SUM_BITS-1:0] dividend_i,
  input  logic        [CNT_BITS-1:0] divisor_i,
  output logic        [Q_BITS-1:0]   quotient_o,
  output wam_pkg::div_status_t       status_o
);

  localparam int CW = $clog2(SUM_BITS + 1);

  logic                busy_q;
  logic                done_q;
  logic [CW-1:0]       cnt_q;
  logic [SUM_BITS-1:0] mag_q;
  logic [CNT_BITS-1:0] rem_q;
  logic [CNT_BITS-1:0] div_q;
  logic                neg_q;

  logic [CNT_BITS:0]   trial;
  logic                ge;
  logic [CNT_BITS-1:0] rem_d;
  logic [SUM_BITS-1:0] q_full;

  assign trial = {rem_q, mag_q[SUM_BITS-1]};
  assign ge    = trial >= {1'b0, div_q};
  always_comb begin
    rem_d = trial[CNT_BITS-1:0];
    if (ge) begin
      rem_d = CNT_BITS'(trial - {1'b0, div_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(SUM_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SUM_BITS-1];
      mag_q <= dividend_i[SUM_BITS-1] ? -dividend_i : dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      mag_q <= {mag_q[SUM_BITS-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign q_full          = neg_q ? -mag_q : mag_q;
  assign quotient_o      = q_full[Q_BITS-1:0];
  assign status_o.busy   = busy_q;
  assign status_o.done   = done_q;

endmodule

// ----- sim/tb_windowed_average_and_minimum_top.sv -----
// Testbench for windowed_average_and_minimum_top: a directed table, then random phases of
// samples under several window sizes; each result is checked against known table values
// or an in-bench window model. Depends on wam_pkg and the design sources.
module tb_windowed_average_and_minimum_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_MAX     = 256;
  localparam int SAMPLE_W       = 16;
  localparam int SUM_W          = SAMPLE_W + $clog2(WINDOW_MAX);
  localparam int CNT_W          = $clog2(WINDOW_MAX + 1);
  localparam int RANDOM_SAMPLES = 1750;
  localparam int HOLD_AT        = 60;
  localparam int HOLD_CYCLES    = 3000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int CYCLE_LIMIT    = 4_000_000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic signed [SUM_W-1:0]    window_sum;
    logic        [CNT_W-1:0]    held_count;
    logic signed [SAMPLE_W-1:0] window_minimum;
  } window_stats_t;

  typedef struct packed {
    logic                          write_cfg;
    logic [wam_pkg::CFG_BITS-1:0]  cfg_value;
    logic signed [SAMPLE_W-1:0]    sample;
    logic                          known;
    window_stats_t                 stats;
  } directed_row_t;

  typedef enum int {DRAW_ANY, DRAW_EXTREME, DRAW_NEAR_ZERO, DRAW_RAIL} draw_mode_e;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [wam_pkg::APB_ADDR_BITS-1:0]   paddr;
  logic [wam_pkg::APB_DATA_BITS-1:0]   pwdata;
  logic [wam_pkg::APB_DATA_BITS-1:0]   prdata;
  logic                                pready;
  logic                                sample_valid_i;
  logic                                sample_ready_o;
  logic signed [SAMPLE_W-1:0]          sample_i;
  logic                                result_valid_o;
  logic                                result_ready_i;
  logic signed [SAMPLE_W-1:0]          average_o;
  logic signed [SUM_W-1:0]             window_sum_o;
  logic        [CNT_W-1:0]             held_count_o;
  logic signed [SAMPLE_W-1:0]          window_minimum_o;

  logic signed [SAMPLE_W-1:0] held_samples[$];
  int unsigned                window_capacity;
  window_stats_t              awaited_stats[$];
  directed_row_t              directed_rows[$];
  int                         mismatches = 0;
  int                         results_seen = 0;
  int                         accepted_samples = 0;
  int                         burst_left = 0;
  int                         cycle_count;

  windowed_average_and_minimum_top #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_W)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .sample_valid_i  (sample_valid_i),
    .sample_ready_o  (sample_ready_o),
    .sample_i        (sample_i),
    .result_valid_o  (result_valid_o),
    .result_ready_i  (result_ready_i),
    .average_o       (average_o),
    .window_sum_o    (window_sum_o),
    .held_count_o    (held_count_o),
    .window_minimum_o(window_minimum_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // zero acts as one, anything past WINDOW_MAX saturates; any write empties the window
  function automatic void resize_window(logic [wam_pkg::CFG_BITS-1:0] value);
    if (value == 0) begin
      window_capacity = 1;
    end else if (value > WINDOW_MAX) begin
      window_capacity = WINDOW_MAX;
    end else begin
      window_capacity = value;
    end
    held_samples.delete();
  endfunction

  function automatic window_stats_t compute_window_stats(logic signed [SAMPLE_W-1:0] s);
    window_stats_t              r;
    longint                     total;
    logic signed [SAMPLE_W-1:0] lowest;
    held_samples.push_back(s);
    if (held_samples.size() > window_capacity) void'(held_samples.pop_front());
    total  = 0;
    lowest = s;
    foreach (held_samples[i]) begin
      total += held_samples[i];
      if (held_samples[i] < lowest) lowest = held_samples[i];
    end
    r.average        = SAMPLE_W'(total / held_samples.size());
    r.window_sum     = SUM_W'(total);
    r.held_count     = CNT_W'(held_samples.size());
    r.window_minimum = lowest;
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_sample(draw_mode_e mode,
                                                            logic signed [SAMPLE_W-1:0] rail);
    case (mode)
      DRAW_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return 16'sh7fff;
          1:       return 16'sh8000;
          2:       return '0;
          3:       return '1;
          default: return 16'sd1;
        endcase
      end
      DRAW_NEAR_ZERO: return SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
      DRAW_RAIL:      return ($urandom_range(0, 7) == 0) ? SAMPLE_W'($urandom) : rail;
      default:        return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic void add_config(logic [wam_pkg::CFG_BITS-1:0] value);
    directed_row_t row;
    row           = '0;
    row.write_cfg = 1'b1;
    row.cfg_value = value;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_sample(logic signed [SAMPLE_W-1:0] s);
    directed_row_t row;
    row        = '0;
    row.sample = s;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_known(logic signed [SAMPLE_W-1:0] s, int avg, int sum, int cnt,
                                    int minimum);
    directed_row_t row;
    row                      = '0;
    row.sample               = s;
    row.known                = 1'b1;
    row.stats.average        = SAMPLE_W'(avg);
    row.stats.window_sum     = SUM_W'(sum);
    row.stats.held_count     = CNT_W'(cnt);
    row.stats.window_minimum = SAMPLE_W'(minimum);
    directed_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at result %0d: %s", results_seen, what);
    mismatches++;
  endtask

  task automatic offer_sample(input logic signed [SAMPLE_W-1:0] s, input logic known,
                              input window_stats_t known_stats);
    window_stats_t predicted;
    int            gap;
    sample_valid_i <= 1'b1;
    sample_i       <= s;
    do @(posedge clk_i); while (!sample_ready_o);
    accepted_samples++;
    predicted = compute_window_stats(s);
    awaited_stats.push_back(known ? known_stats : predicted);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 7);
      case ($urandom_range(0, 7))
        0, 1, 2: gap = 0;
        7:       gap = $urandom_range(100, 300);
        default: gap = $urandom_range(1, 20);
      endcase
      if (gap > 0) begin
        sample_valid_i <= 1'b0;
        sample_i       <= SAMPLE_W'($urandom);
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // only while idle: the window is emptied by the write
  task automatic write_window_size(input logic [wam_pkg::CFG_BITS-1:0] value);
    sample_valid_i <= 1'b0;
    while (awaited_stats.size() != 0) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= wam_pkg::APB_ADDR_BITS'({wam_pkg::REG_WINDOW_SIZE, 2'b00});
    pwdata  <= wam_pkg::APB_DATA_BITS'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    resize_window(value);
  endtask

  always @(posedge clk_i) begin : watch_results
    window_stats_t got;
    window_stats_t want;
    if (rst_ni && result_valid_o && result_ready_i) begin
      got.average        = average_o;
      got.window_sum     = window_sum_o;
      got.held_count     = held_count_o;
      got.window_minimum = window_minimum_o;
      if (awaited_stats.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = awaited_stats.pop_front();
        if (got.average !== want.average)
          report_mismatch($sformatf("average %0d, expected %0d", got.average, want.average));
        if (got.window_sum !== want.window_sum)
          report_mismatch($sformatf("window_sum %0d, expected %0d", got.window_sum,
                                    want.window_sum));
        if (got.held_count !== want.held_count)
          report_mismatch($sformatf("held_count %0d, expected %0d", got.held_count,
                                    want.held_count));
        if (got.window_minimum !== want.window_minimum)
          report_mismatch($sformatf("window_minimum %0d, expected %0d", got.window_minimum,
                                    want.window_minimum));
      end
      results_seen++;
    end
  end

  // random stall pattern, plus one long hold-off to back the block up
  initial begin : result_sink
    bit held_off;
    int stall;
    held_off       = 1'b0;
    result_ready_i = 1'b0;
    @(posedge clk_i);
    forever begin
      if (!held_off && accepted_samples >= HOLD_AT) begin
        held_off = 1'b1;
        result_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      result_ready_i <= 1'b1;
      repeat (($urandom_range(0, 4) == 0) ? $urandom_range(200, 600) : $urandom_range(1, 30))
        @(posedge clk_i);
      stall = $urandom_range(0, 30);
      if (stall > 0) begin
        result_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    directed_row_t                 row;
    logic [wam_pkg::CFG_BITS-1:0]  size;
    draw_mode_e                    mode;
    logic signed [SAMPLE_W-1:0]    rail;
    int                            phase_len;
    int                            sent;
    int                            phase;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    sample_valid_i = 1'b0;
    sample_i       = '0;
    resize_window(wam_pkg::WINDOW_SIZE_RESET);

    // reset window of 16
    add_known(16'sh7fff, 32767, 32767, 1, 32767);
    add_known(16'sh8000, 0, -1, 2, -32768);
    add_known(-16'sd1, 0, -2, 3, -32768);
    add_sample(16'sd0);
    add_config(9'd1);
    add_known(16'sh8000, -32768, -32768, 1, -32768);
    add_known(16'sh7fff, 32767, 32767, 1, 32767);
    // zero behaves as a window of one
    add_config(9'd0);
    add_known(16'sd5, 5, 5, 1, 5);
    add_known(-16'sd7, -7, -7, 1, -7);
    add_config(9'd3);
    add_sample(16'sd10);
    add_sample(-16'sd20);
    add_sample(16'sd30);
    add_sample(16'sd40);
    add_sample(-16'sd50);
    // oversize saturates to WINDOW_MAX
    add_config(9'd511);
    add_sample(16'sh7fff);
    add_sample(16'sh7fff);
    add_sample(16'sh8000);
    add_config(9'd256);
    add_sample(16'sd1);
    add_sample(-16'sd1);
    add_config(9'd2);
    add_sample(16'sh5555);
    add_sample(16'shaaaa);
    add_sample(16'sd3);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.write_cfg) begin
        write_window_size(row.cfg_value);
      end else begin
        offer_sample(row.sample, row.known, row.stats);
      end
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_SAMPLES) begin
      if (phase > 0) begin
        case ($urandom_range(0, 7))
          0:       size = 9'd1;
          1:       size = 9'd2;
          2:       size = 9'd256;
          3:       size = 9'd0;
          4:       size = $urandom_range(0, 1) ? 9'd511
                                               : wam_pkg::CFG_BITS'($urandom_range(257, 510));
          5:       size = wam_pkg::CFG_BITS'($urandom_range(3, 255));
          default: size = wam_pkg::CFG_BITS'($urandom_range(3, 40));
        endcase
        write_window_size(size);
      end
      mode      = (phase == 0) ? DRAW_ANY : draw_mode_e'($urandom_range(0, 3));
      rail      = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      phase_len = (phase == 0) ? 200 : $urandom_range(40, 320);
      for (int k = 0; k < phase_len && sent < RANDOM_SAMPLES; k++) begin
        offer_sample(draw_sample(mode, rail), 1'b0, '0);
        sent++;
      end
      phase++;
    end

    sample_valid_i <= 1'b0;
    while (awaited_stats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
